FILE: src/poly_bisection_inverse_defines.svh
// assertion macros shared by the poly bisection inverse block
`ifndef POLY_BISECTION_INVERSE_DEFINES_SVH
`define POLY_BISECTION_INVERSE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PBI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PBI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/pbi_pkg.sv
// types, microcode table and fixed-point helpers of the poly bisection inverse
`timescale 1ns / 1ps
package pbi_pkg;

  localparam int unsigned QW      = 24;
  localparam int unsigned AW      = 23;
  localparam int unsigned PW      = 2 * QW;
  localparam int unsigned N_COEF  = 5;
  localparam int unsigned COEF_IW = 3;
  localparam int unsigned CFG_IW  = 3;
  localparam int unsigned STEP_W  = 3;
  localparam int signed   TOL_Q16 = 65;

  // register indexes of the configuration port
  localparam logic [CFG_IW-1:0] REG_MAX_ALPHA = 3'd0;
  localparam logic [CFG_IW-1:0] REG_COEF_0    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_COEF_4    = 3'd5;

  // microcode step addresses
  localparam logic [STEP_W-1:0] ST_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] ST_MID  = 3'd1;
  localparam logic [STEP_W-1:0] ST_MUL  = 3'd2;
  localparam logic [STEP_W-1:0] ST_ADD  = 3'd3;
  localparam logic [STEP_W-1:0] ST_TEST = 3'd4;
  localparam logic [STEP_W-1:0] ST_DONE = 3'd5;

  typedef enum logic [5:0] {
    OP_IDLE = 6'b000001,
    OP_MID  = 6'b000010,
    OP_MUL  = 6'b000100,
    OP_ADD  = 6'b001000,
    OP_TEST = 6'b010000,
    OP_DONE = 6'b100000
  } op_t;

  typedef enum logic [2:0] {
    CND_NEXT = 3'd0,
    CND_JUMP = 3'd1,
    CND_WAIT = 3'd2,
    CND_KNZ  = 3'd3,
    CND_MORE = 3'd4
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // datapath conditions seen by the sequencer
  typedef struct packed {
    logic start;
    logic k_nz;
    logic more;
  } status_t;

  // control store: one word per step
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    unique case (step)
      ST_IDLE: w = '{op: OP_IDLE, cond: CND_WAIT, target: ST_IDLE};
      ST_MID:  w = '{op: OP_MID,  cond: CND_NEXT, target: ST_MID};
      ST_MUL:  w = '{op: OP_MUL,  cond: CND_NEXT, target: ST_MUL};
      ST_ADD:  w = '{op: OP_ADD,  cond: CND_KNZ,  target: ST_MUL};
      ST_TEST: w = '{op: OP_TEST, cond: CND_MORE, target: ST_MID};
      ST_DONE: w = '{op: OP_DONE, cond: CND_JUMP, target: ST_IDLE};
      default: w = '{op: OP_DONE, cond: CND_JUMP, target: ST_IDLE};
    endcase
    return w;
  endfunction

  // clamp to the signed 24-bit range
  function automatic logic signed [QW-1:0] sat24(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] lo;
    hi = PW'(signed'({1'b0, {(QW-1){1'b1}}}));
    lo = -hi - PW'(1);
    if (v > hi) return QW'(hi);
    if (v < lo) return QW'(lo);
    return v[QW-1:0];
  endfunction

endpackage

FILE: src/poly_bisection_inverse.sv
// Polynomial inverse by bisection: top level with datapath, registers and checks.
// Each bisection step is a midpoint, then a multiply and an add per Horner term on one
// shared 24x24 multiplier, then a test.
// Result strobe follows the test that ends the search, at most STEP_LIMIT+2 steps.
// Busy drops after the strobe cycle.
// Synchronous active-low reset: sequencer idle, no strobe, registers to their reset values.
`timescale 1ns / 1ps
`include "poly_bisection_inverse_defines.svh"
module poly_bisection_inverse
  import pbi_pkg::*;
#(
  parameter int POLY_DEGREE = 4,
  parameter int STEP_LIMIT  = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [QW-1:0]     in_target_lift,
  output logic                     out_valid,
  output logic signed [QW-1:0]     out_found_alpha,
  output logic                     out_failed,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IW-1:0]        cfg_index,
  input  logic [QW-1:0]            cfg_data
);

  localparam int KW = (POLY_DEGREE > 1) ? $clog2(POLY_DEGREE) : 1;
  localparam int CW = $clog2(STEP_LIMIT + 2);

  ctrl_t   ctrl;
  status_t status;

  logic [AW-1:0]           max_alpha_r;
  logic signed [QW-1:0]    coef_r [N_COEF];
  logic signed [QW-1:0]    target_r;
  logic signed [QW-1:0]    left_r;
  logic signed [QW-1:0]    right_r;
  logic signed [QW-1:0]    center_r;
  logic signed [QW-1:0]    acc_r;
  logic signed [PW-1:0]    prod_r;
  logic [KW-1:0]           k_r;
  logic [CW-1:0]           count_r;

  logic                    accept;
  logic signed [QW:0]      sum_lr;
  logic signed [QW-1:0]    prod_q;
  logic signed [QW-1:0]    coef_k;
  logic signed [QW-1:0]    acc_add;
  logic signed [QW:0]      diff;
  logic                    fail;
  logic                    conv;

  pbi_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  assign busy      = (ctrl.op != OP_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // horner term: floor of product by 2^16, saturate, add coefficient, saturate
  assign coef_k  = coef_r[COEF_IW'(k_r)];
  assign prod_q  = sat24(prod_r >>> 16);
  assign acc_add = sat24(PW'(prod_q) + PW'(coef_k));

  // midpoint and convergence test
  assign sum_lr = (QW+1)'(left_r) + (QW+1)'(right_r);
  assign diff   = (QW+1)'(acc_r) - (QW+1)'(target_r);
  assign fail   = count_r > CW'(STEP_LIMIT);
  assign conv   = (diff <= (QW+1)'(TOL_Q16)) && (diff >= -(QW+1)'(TOL_Q16));

  assign status = '{start: start, k_nz: (k_r != '0), more: !fail && !conv};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_alpha_r <= AW'(19661);
      for (int i = 0; i < N_COEF; i++) coef_r[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MAX_ALPHA) begin
        max_alpha_r <= cfg_data[AW-1:0];
      end else if (cfg_index >= REG_COEF_0 && cfg_index <= REG_COEF_4) begin
        coef_r[COEF_IW'(cfg_index - REG_COEF_0)] <= cfg_data;
      end
    end
  end

  // datapath driven by the control word
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_IDLE: begin
        if (accept) begin
          target_r <= in_target_lift;
          left_r   <= -QW'(signed'({1'b0, max_alpha_r}));
          right_r  <= QW'(signed'({1'b0, max_alpha_r}));
          count_r  <= '0;
        end
      end
      OP_MID: begin
        center_r <= sum_lr[QW:1];
        acc_r    <= coef_r[COEF_IW'(POLY_DEGREE)];
        k_r      <= KW'(POLY_DEGREE - 1);
      end
      OP_MUL: begin
        prod_r <= acc_r * center_r;
      end
      OP_ADD: begin
        acc_r <= acc_add;
        if (k_r != '0) k_r <= k_r - KW'(1);
      end
      OP_TEST: begin
        if (acc_r > target_r) right_r <= center_r;
        else left_r <= center_r;
        count_r <= count_r + CW'(1);
      end
      OP_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // result strobe and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (ctrl.op == OP_TEST) && (fail || conv);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_TEST) begin
      out_found_alpha <= fail ? '0 : center_r;
      out_failed      <= fail;
    end
  end

  // checks
  `PBI_ASSERT_NEXT(a_accept_busy, accept, busy, "busy not raised after accept")
  `PBI_ASSERT_NOW(a_valid_busy, out_valid, busy, "result strobe outside a transaction")
  `PBI_ASSERT_NEXT(a_one_strobe, out_valid, !out_valid, "result strobe longer than one cycle")
  `PBI_ASSERT_NOW(a_fail_zero, out_valid && out_failed, out_found_alpha == '0,
                  "failed result with nonzero angle")

endmodule

FILE: src/pbi_seq.sv
// microcode sequencer: step counter, control store and conditional jumps
`timescale 1ns / 1ps
module pbi_seq
  import pbi_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  status_t status,
  output ctrl_t   ctrl
);

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic              take;

  assign ctrl = ucode(step_r);

  // jump condition select
  always_comb begin
    unique case (ctrl.cond)
      CND_NEXT: take = 1'b0;
      CND_JUMP: take = 1'b1;
      CND_WAIT: take = !status.start;
      CND_KNZ:  take = status.k_nz;
      CND_MORE: take = status.more;
      default:  take = 1'b1;
    endcase
    step_nxt = take ? ctrl.target : step_r + STEP_W'(1);
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

FILE: verif/poly_bisection_inverse_checker.sv
// scoreboard that predicts and checks every poly bisection inverse transaction
`timescale 1ns / 1ps
module poly_bisection_inverse_checker
  import pbi_pkg::*;
#(
  parameter int POLY_DEGREE = 4,
  parameter int STEP_LIMIT  = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic signed [QW-1:0] in_target_lift,
  input  logic                 out_valid,
  input  logic signed [QW-1:0] out_found_alpha,
  input  logic                 out_failed,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IW-1:0]    cfg_index,
  input  logic [QW-1:0]        cfg_data,
  output int                   mismatches,
  output int                   outstanding,
  output int                   no_root_count,
  output int                   roots_checked
);

  localparam longint Q_HI             = 64'sd8388607;
  localparam longint Q_LO             = -64'sd8388608;
  localparam int     ALPHA_SPAN_RESET = 19661;

  typedef struct {
    logic signed [QW-1:0] target;
    logic signed [QW-1:0] alpha;
    logic                 failed;
  } root_t;

  // shadow copy of the register file
  logic [AW-1:0]        alpha_span;
  logic signed [QW-1:0] lift_coef [N_COEF];
  root_t                expected_roots [$];
  int                   err_count;
  int                   checked_count;
  int                   no_root_seen;

  function automatic longint clamp_q(input longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  // horner evaluation of the lift curve, product floored to q16 and saturated
  function automatic longint lift_at_angle(input longint x);
    int     order;
    longint acc;
    order = (POLY_DEGREE < 1) ? 1 : ((POLY_DEGREE > 4) ? 4 : POLY_DEGREE);
    acc   = lift_coef[order];
    for (int i = order - 1; i >= 0; i--)
      acc = clamp_q(clamp_q((acc * x) >>> 16) + lift_coef[i]);
    return acc;
  endfunction

  // bisection over the symmetric span; the last allowed step fails before its test
  function automatic root_t solve_alpha(input logic signed [QW-1:0] target);
    root_t  r;
    longint lo_b;
    longint hi_b;
    longint mid;
    longint val;
    longint gap;
    r.target = target;
    r.alpha  = '0;
    r.failed = 1'b1;
    lo_b     = -longint'(alpha_span);
    hi_b     = longint'(alpha_span);
    for (int n = 1; n <= STEP_LIMIT + 1; n++) begin
      mid = (lo_b + hi_b) >>> 1;
      val = lift_at_angle(mid);
      if (val > target) hi_b = mid;
      else lo_b = mid;
      gap = val - target;
      if (gap < 0) gap = -gap;
      if (gap <= TOL_Q16) begin
        r.alpha  = QW'(mid);
        r.failed = 1'b0;
        return r;
      end
    end
    return r;
  endfunction

  // register writes, result compare and prediction, all on the same edge
  always @(posedge clk) begin : track
    root_t exp_r;
    if (!rst_n) begin
      alpha_span = AW'(ALPHA_SPAN_RESET);
      for (int k = 0; k < N_COEF; k++) lift_coef[k] = '0;
      expected_roots.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAX_ALPHA)
          alpha_span = cfg_data[AW-1:0];
        else if (cfg_index >= REG_COEF_0 && cfg_index <= REG_COEF_4)
          lift_coef[cfg_index - REG_COEF_0] = cfg_data;
      end
      // result transaction against the oldest prediction
      if (out_valid) begin
        if (expected_roots.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual found_alpha %0d failed %0b",
                   $time, out_found_alpha, out_failed);
          err_count++;
        end else begin
          exp_r = expected_roots.pop_front();
          checked_count++;
          if (exp_r.failed) no_root_seen++;
          if (out_found_alpha !== exp_r.alpha) begin
            $display("%0t: found_alpha mismatch for target %0d: expected %0d, actual %0d",
                     $time, exp_r.target, exp_r.alpha, out_found_alpha);
            err_count++;
          end
          if (out_failed !== exp_r.failed) begin
            $display("%0t: failed mismatch for target %0d: expected %0b, actual %0b",
                     $time, exp_r.target, exp_r.failed, out_failed);
            err_count++;
          end
        end
      end
      // accepted target transaction
      if (start && !busy) expected_roots.push_back(solve_alpha(in_target_lift));
    end
    outstanding   <= expected_roots.size();
    mismatches    <= err_count;
    roots_checked <= checked_count;
    no_root_count <= no_root_seen;
  end

endmodule

FILE: verif/testbench.sv
// stimulus, register settings and verdict for the poly bisection inverse block
`timescale 1ns / 1ps
module testbench
  import pbi_pkg::*;
();

  localparam int     POLY_DEGREE    = 4;
  localparam int     STEP_LIMIT     = 256;
  localparam longint Q_HI           = 64'sd8388607;
  localparam longint Q_LO           = -64'sd8388608;
  localparam longint ALPHA_SPAN_MAX = 64'sd8388607;
  localparam int     NUM_PHASES     = 11;

  // indexes past the last coefficient, decoded by nothing
  localparam logic [CFG_IW-1:0] REG_SPARE_LO = REG_COEF_4 + 3'd1;
  localparam logic [CFG_IW-1:0] REG_SPARE_HI = REG_COEF_4 + 3'd2;

  typedef enum int {
    CURVE_TYPICAL,
    CURVE_FLAT_SPAN,
    CURVE_CEILING,
    CURVE_FLOOR,
    CURVE_FALLING
  } curve_kind_t;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 start          = 1'b0;
  logic signed [QW-1:0] in_target_lift = '0;
  logic                 cfg_valid      = 1'b0;
  logic [CFG_IW-1:0]    cfg_index      = '0;
  logic [QW-1:0]        cfg_data       = '0;
  logic                 busy;
  logic                 out_valid;
  logic signed [QW-1:0] out_found_alpha;
  logic                 out_failed;
  logic                 cfg_ready;
  int                   mismatches;
  int                   outstanding;
  int                   no_root_count;
  int                   roots_checked;

  // stimulus side copy of the current curve, used to load the registers and aim targets
  longint      span_now;
  longint      coef_now [N_COEF];
  int          send_gap_pct;
  int          items_sent;
  int          settings_used;
  curve_kind_t plan [NUM_PHASES] = '{CURVE_TYPICAL, CURVE_TYPICAL, CURVE_TYPICAL,
                                     CURVE_FLAT_SPAN, CURVE_TYPICAL, CURVE_TYPICAL,
                                     CURVE_CEILING, CURVE_FLOOR, CURVE_TYPICAL,
                                     CURVE_FALLING, CURVE_TYPICAL};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  poly_bisection_inverse #(
    .POLY_DEGREE(POLY_DEGREE),
    .STEP_LIMIT (STEP_LIMIT)
  ) u_dut (.*);

  poly_bisection_inverse_checker #(
    .POLY_DEGREE(POLY_DEGREE),
    .STEP_LIMIT (STEP_LIMIT)
  ) u_checker (.*);

  // one register write transaction, valid left high for a following write
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [QW-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // write span and all coefficients, span top bit is don't care
  task automatic load_curve();
    write_reg(REG_MAX_ALPHA, {1'($urandom_range(0, 1)), AW'(span_now)});
    for (int k = 0; k < N_COEF; k++)
      write_reg(REG_COEF_0 + CFG_IW'(k), QW'(coef_now[k]));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // let every outstanding search finish and the block go idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one target transaction with optional idle cycles ahead of it
  task automatic push_target(input longint t);
    while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_target_lift <= QW'(t);
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  function automatic longint rand_between(input longint lo, input longint hi);
    return lo + longint'($urandom_range(0, 32'(hi - lo)));
  endfunction

  // straight line through the constant and linear terms
  function automatic longint near_lift(input longint a);
    return coef_now[0] + ((coef_now[1] * a) >>> 16);
  endfunction

  // mostly on the curve, some just past either end, some anywhere
  function automatic longint pick_target();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return near_lift(rand_between(-span_now, span_now)) + rand_between(-40, 40);
    if (roll < 88) return near_lift(roll[0] ? span_now + 1000 : -span_now - 1000);
    return longint'(signed'(QW'($urandom)));
  endfunction

  task automatic pick_curve(input curve_kind_t kind);
    case (kind) inside
      CURVE_CEILING, CURVE_FLOOR: begin
        span_now = ALPHA_SPAN_MAX;
        for (int k = 0; k < N_COEF; k++) coef_now[k] = (kind == CURVE_CEILING) ? Q_HI : Q_LO;
      end
      CURVE_FALLING: begin
        span_now    = rand_between(6554, 65536);
        coef_now[0] = rand_between(-32768, 32768);
        coef_now[1] = -rand_between(131072, 458752);
        coef_now[2] = 0;
        coef_now[3] = 0;
        coef_now[4] = 0;
      end
      default: begin
        span_now    = (kind == CURVE_FLAT_SPAN) ? 0 : rand_between(3277, 131072);
        coef_now[0] = rand_between(-32768, 32768);
        coef_now[1] = rand_between(131072, 458752);
        coef_now[2] = rand_between(-16384, 16384);
        coef_now[3] = rand_between(-8192, 8192);
        coef_now[4] = rand_between(-4096, 4096);
      end
    endcase
  endtask

  function automatic int items_for(input curve_kind_t kind);
    case (kind)
      CURVE_TYPICAL:   return 60;
      CURVE_FLAT_SPAN: return 10;
      CURVE_FALLING:   return 6;
      default:         return 4;
    endcase
  endfunction

  initial begin
    send_gap_pct  = 0;
    items_sent    = 0;
    settings_used = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: flat zero curve, only targets within tolerance of zero converge
    push_target(0);
    push_target(TOL_Q16);
    push_target(-TOL_Q16);
    push_target(TOL_Q16 + 1);
    push_target(-TOL_Q16 - 1);
    push_target(Q_HI);
    push_target(Q_LO);
    drain();

    // a realistic lift curve, unused register indexes written too
    write_reg(REG_SPARE_LO, QW'($urandom));
    write_reg(REG_SPARE_HI, QW'($urandom));
    span_now = 19661;
    coef_now = '{6554, 411775, -32768, 9830, 1000};
    load_curve();
    push_target(coef_now[0]);
    push_target(near_lift(span_now));
    push_target(near_lift(-span_now));
    push_target(near_lift(span_now / 2));
    push_target(Q_HI);
    push_target(Q_LO);
    drain();

    // zero span: every midpoint is zero
    span_now = 0;
    coef_now = '{1000, 411775, 0, 0, 0};
    load_curve();
    push_target(1000);
    push_target(1000 + TOL_Q16);
    push_target(1000 - TOL_Q16);
    push_target(1000 + TOL_Q16 + 1);
    push_target(1000 - TOL_Q16 - 1);
    drain();

    // random phases with rotating sender idling
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      pick_curve(plan[ph]);
      load_curve();
      send_gap_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 68 : 31);
      for (int n = 0; n < items_for(plan[ph]); n++) push_target(pick_target());
      drain();
    end

    repeat (16) @(posedge clk);
    $display("covered %0d target transactions over %0d register settings, span zero to full",
             items_sent, settings_used + 1);
    $display("%0d results checked, %0d of them searches that ran out of steps",
             roots_checked, no_root_count);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
